FILE: sv/assert_macros.svh
// Shared assertion macros for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/rrle_pkg.sv
// ----------------------------------------------------------------------------
// rrle_pkg
// Types, constants and the float conversion of the RGBE scanline decoder.
// ----------------------------------------------------------------------------
package rrle_pkg;

    localparam int MAX_LINE_DEF = 4096;
    localparam int LEN_W        = 15;
    localparam int SUM_W        = 16;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_PIXEL      = 3'd1,
        ST_BUSY       = 3'd2,
        ST_BAD_HEADER = 3'd3,
        ST_OVERRUN    = 3'd4,
        ST_DONE       = 3'd5
    } t_status;

    // One plane entry: a literal byte, or the head of a run.
    typedef struct packed {
        logic       is_run;
        logic [6:0] count;
        logic [7:0] value;
    } t_entry;

    typedef struct packed {
        logic    valid;
        t_status status;
        logic    pixel;
        logic    lol;
        logic    loi;
    } t_s1;

    // m/256 * 2^(e-128) as an IEEE single; always exact.
    function automatic logic [31:0] to_single(input logic [7:0] m, input logic [7:0] e);
        logic [2:0]  p;
        logic [8:0]  pe;
        logic [31:0] mant;
        logic [31:0] res;
        p = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (m[i]) begin
                p = 3'(i);
            end
        end
        pe = {1'b0, e} + {6'd0, p};
        mant = {24'd0, m} << (5'd23 - {2'd0, p});
        if (m == 8'd0) begin
            res = 32'd0;
        end else if (pe >= 9'd10) begin
            res = {1'b0, 8'(pe - 9'd9), mant[22:0]};
        end else begin
            res = {24'd0, m} << (e[4:0] + 5'd13);
        end
        return res;
    endfunction

endpackage

FILE: sv/rrle_front.sv
// ----------------------------------------------------------------------------
// rrle_front
// Byte parser, plane stores and drain control: the first pipeline stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rrle_front #(
    parameter int MAX_LINE = rrle_pkg::MAX_LINE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_adv,
    input  logic                i_command,
    input  logic [7:0]          i_byte,
    input  logic [15:0]         i_height,
    output rrle_pkg::t_s1       o_s1,
    output rrle_pkg::t_entry    o_rd [4]
);
    localparam int PW = $clog2(MAX_LINE + 1);
    localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

    rrle_pkg::t_entry mem0 [MAX_LINE];
    rrle_pkg::t_entry mem1 [MAX_LINE];
    rrle_pkg::t_entry mem2 [MAX_LINE];
    rrle_pkg::t_entry mem3 [MAX_LINE];

    logic [1:0]                r_hdr_idx, n_hdr_idx;
    logic                      r_in_hdr, n_in_hdr;
    logic [rrle_pkg::LEN_W-1:0] r_len, n_len;
    logic [1:0]                r_chan, n_chan;
    logic [PW-1:0]             r_fill, n_fill;
    logic [7:0]                r_pend, n_pend;
    logic                      r_run, n_run;
    logic                      r_expect, n_expect;
    logic [15:0]               r_lines, n_lines;
    logic [PW-1:0]             r_drain, n_drain;
    logic                      r_ready, n_ready;
    rrle_pkg::t_status         r_err, n_err;
    rrle_pkg::t_s1             r_s1, n_s1;

    logic                      wr_en;
    rrle_pkg::t_entry          wr_data;
    logic [7:0]                cnt;
    logic [rrle_pkg::SUM_W-1:0] fill_sum, drain_sum;
    logic [rrle_pkg::LEN_W-1:0] full_len;

    always_comb begin
        n_hdr_idx = r_hdr_idx;
        n_in_hdr  = r_in_hdr;
        n_len     = r_len;
        n_chan    = r_chan;
        n_fill    = r_fill;
        n_pend    = r_pend;
        n_run     = r_run;
        n_expect  = r_expect;
        n_lines   = r_lines;
        n_drain   = r_drain;
        n_ready   = r_ready;
        n_err     = r_err;
        n_s1      = '{valid: 1'b1, status: rrle_pkg::ST_ACCEPTED, pixel: 1'b0,
                      lol: 1'b0, loi: 1'b0};
        wr_en     = 1'b0;
        wr_data   = '{is_run: 1'b0, count: 7'd0, value: i_byte};
        cnt       = i_byte[7] && (i_byte != 8'd128) ? {1'b0, i_byte[6:0]} : i_byte;
        fill_sum  = rrle_pkg::SUM_W'(r_fill) + rrle_pkg::SUM_W'(cnt);
        drain_sum = rrle_pkg::SUM_W'(r_drain) + rrle_pkg::SUM_W'(1);
        full_len  = {r_len[rrle_pkg::LEN_W-1:8], i_byte};

        if (r_err != rrle_pkg::ST_ACCEPTED) begin
            n_s1.status = r_err;
        end else if (!i_command) begin
            if (r_ready) begin
                n_s1.status = rrle_pkg::ST_BUSY;
            end else if (r_lines >= i_height) begin
                n_s1.status = rrle_pkg::ST_DONE;
            end else if (r_in_hdr) begin
                if (r_hdr_idx < 2'd2) begin
                    if (i_byte != 8'd2) begin
                        n_err       = rrle_pkg::ST_BAD_HEADER;
                        n_s1.status = rrle_pkg::ST_BAD_HEADER;
                    end else begin
                        n_hdr_idx = r_hdr_idx + 2'd1;
                    end
                end else if (r_hdr_idx == 2'd2) begin
                    if (i_byte[7]) begin
                        n_err       = rrle_pkg::ST_OVERRUN;
                        n_s1.status = rrle_pkg::ST_OVERRUN;
                    end else begin
                        n_len     = {i_byte[6:0], 8'd0};
                        n_hdr_idx = 2'd3;
                    end
                end else begin
                    n_len = full_len;
                    if (32'(full_len) > 32'(MAX_LINE)) begin
                        n_err       = rrle_pkg::ST_OVERRUN;
                        n_s1.status = rrle_pkg::ST_OVERRUN;
                    end else begin
                        n_hdr_idx = 2'd0;
                        if (full_len == '0) begin
                            n_lines = r_lines + 16'd1;
                        end else begin
                            n_in_hdr = 1'b0;
                            n_chan   = 2'd0;
                            n_fill   = '0;
                            n_expect = 1'b1;
                            n_pend   = 8'd0;
                        end
                    end
                end
            end else if (r_expect) begin
                if (cnt != 8'd0) begin
                    if (fill_sum > rrle_pkg::SUM_W'(r_len)) begin
                        n_err       = rrle_pkg::ST_OVERRUN;
                        n_s1.status = rrle_pkg::ST_OVERRUN;
                    end else begin
                        n_pend   = cnt;
                        n_run    = i_byte > 8'd128;
                        n_expect = 1'b0;
                    end
                end
            end else begin
                wr_en = 1'b1;
                if (r_run) begin
                    wr_data.is_run = 1'b1;
                    wr_data.count  = r_pend[6:0];
                    n_fill         = r_fill + PW'(r_pend);
                    n_pend         = 8'd0;
                end else begin
                    n_fill = r_fill + PW'(1);
                    n_pend = r_pend - 8'd1;
                end
                if (n_pend == 8'd0) begin
                    n_expect = 1'b1;
                end
                if (rrle_pkg::SUM_W'(n_fill) >= rrle_pkg::SUM_W'(r_len)) begin
                    n_fill   = '0;
                    n_expect = 1'b1;
                    n_pend   = 8'd0;
                    if (r_chan == 2'd3) begin
                        n_chan    = 2'd0;
                        n_in_hdr  = 1'b1;
                        n_hdr_idx = 2'd0;
                        n_ready   = 1'b1;
                        n_drain   = '0;
                    end else begin
                        n_chan = r_chan + 2'd1;
                    end
                end
            end
        end else if (r_ready) begin
            n_s1.status = rrle_pkg::ST_PIXEL;
            n_s1.pixel  = 1'b1;
            n_drain     = r_drain + PW'(1);
            if (drain_sum >= rrle_pkg::SUM_W'(r_len)) begin
                n_s1.lol = 1'b1;
                n_s1.loi = (17'(r_lines) + 17'd1) == 17'(i_height);
                n_ready  = 1'b0;
                n_drain  = '0;
                if (r_lines != 16'hFFFF) begin
                    n_lines = r_lines + 16'd1;
                end
            end
        end else if (r_lines >= i_height) begin
            n_s1.status = rrle_pkg::ST_DONE;
        end else begin
            n_s1.status = rrle_pkg::ST_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx <= 2'd0;
            r_in_hdr  <= 1'b1;
            r_len     <= '0;
            r_chan    <= 2'd0;
            r_fill    <= '0;
            r_pend    <= 8'd0;
            r_run     <= 1'b0;
            r_expect  <= 1'b1;
            r_lines   <= 16'd0;
            r_drain   <= '0;
            r_ready   <= 1'b0;
            r_err     <= rrle_pkg::ST_ACCEPTED;
            r_s1      <= '0;
        end else if (i_accept) begin
            r_hdr_idx <= n_hdr_idx;
            r_in_hdr  <= n_in_hdr;
            r_len     <= n_len;
            r_chan    <= n_chan;
            r_fill    <= n_fill;
            r_pend    <= n_pend;
            r_run     <= n_run;
            r_expect  <= n_expect;
            r_lines   <= n_lines;
            r_drain   <= n_drain;
            r_ready   <= n_ready;
            r_err     <= n_err;
            r_s1      <= n_s1;
        end else if (i_adv) begin
            r_s1.valid <= 1'b0;
        end
    end

    // Plane stores: one write lane per channel, all read at the drain address.
    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) begin
            case (r_chan)
                2'd0: mem0[r_fill[AW-1:0]] <= wr_data;
                2'd1: mem1[r_fill[AW-1:0]] <= wr_data;
                2'd2: mem2[r_fill[AW-1:0]] <= wr_data;
                default: mem3[r_fill[AW-1:0]] <= wr_data;
            endcase
        end
        if (i_accept) begin
            o_rd[0] <= mem0[r_drain[AW-1:0]];
            o_rd[1] <= mem1[r_drain[AW-1:0]];
            o_rd[2] <= mem2[r_drain[AW-1:0]];
            o_rd[3] <= mem3[r_drain[AW-1:0]];
        end
    end

    assign o_s1 = r_s1;

    `ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_err != rrle_pkg::ST_ACCEPTED, r_err == $past(r_err))
    `ASSERT_ALWAYS(a_fill_in_line, i_clk, i_rst_n, rrle_pkg::SUM_W'(r_fill) <= rrle_pkg::SUM_W'(r_len) || r_in_hdr)
    `ASSERT_ALWAYS(a_drain_in_line, i_clk, i_rst_n, !r_ready || rrle_pkg::SUM_W'(r_drain) < rrle_pkg::SUM_W'(r_len))
    `ASSERT_ALWAYS(a_no_fill_while_ready, i_clk, i_rst_n, !(r_ready && !r_in_hdr))
endmodule

FILE: sv/rrle_conv.sv
// ----------------------------------------------------------------------------
// rrle_conv
// Run expansion per plane and float conversion into the result register.
// ----------------------------------------------------------------------------
module rrle_conv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  rrle_pkg::t_s1      i_s1,
    input  rrle_pkg::t_entry   i_rd [4],
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [31:0]        o_red,
    output logic [31:0]        o_green,
    output logic [31:0]        o_blue,
    output logic               o_lol,
    output logic               o_loi
);
    logic [6:0]  r_left [4];
    logic [7:0]  r_val  [4];
    logic [6:0]  n_left [4];
    logic [7:0]  n_val  [4];
    logic [7:0]  chan   [4];
    logic        r_valid;
    logic [2:0]  r_status;
    logic [31:0] r_red, r_green, r_blue;
    logic        r_lol, r_loi;
    logic        take;

    assign take = i_adv && i_s1.valid && i_s1.pixel;

    // A run head carries its count; later positions of the run are never stored.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_left[c] = r_left[c];
            n_val[c]  = r_val[c];
            if (r_left[c] != 7'd0) begin
                chan[c]   = r_val[c];
                n_left[c] = r_left[c] - 7'd1;
            end else begin
                chan[c] = i_rd[c].value;
                if (i_rd[c].is_run) begin
                    n_left[c] = i_rd[c].count - 7'd1;
                    n_val[c]  = i_rd[c].value;
                end
            end
            if (i_s1.lol) begin
                n_left[c] = 7'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int c = 0; c < 4; c++) begin
                r_left[c] <= 7'd0;
            end
        end else if (i_adv) begin
            r_valid <= i_s1.valid;
            if (take) begin
                r_left <= n_left;
                r_val  <= n_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_status <= i_s1.status;
            r_lol    <= i_s1.lol;
            r_loi    <= i_s1.loi;
            r_red    <= i_s1.pixel ? rrle_pkg::to_single(chan[0], chan[3]) : 32'd0;
            r_green  <= i_s1.pixel ? rrle_pkg::to_single(chan[1], chan[3]) : 32'd0;
            r_blue   <= i_s1.pixel ? rrle_pkg::to_single(chan[2], chan[3]) : 32'd0;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
    assign o_lol    = r_lol;
    assign o_loi    = r_loi;
endmodule

FILE: sv/rgbe_rle_scanline_decoder.sv
// ----------------------------------------------------------------------------
// rgbe_rle_scanline_decoder
// Decodes run-length coded RGBE scanlines and drains pixels as IEEE singles.
// ----------------------------------------------------------------------------
// The slave channel carries one beat per file byte (tuser 0, byte in tdata)
// or per drain request (tuser 1). Every slave beat yields exactly one master
// beat: a status in tuser, the three float patterns and the last-of-image
// flag in tdata, and last-of-line on tlast.
// A beat enters the parser register, then the conversion stage loads the
// result register. One beat is taken every cycle while the master side
// keeps up; runs are kept as run heads in four plane stores, so even a
// long run costs a single memory write.
// After reset the decoder expects a scanline header, no line is held and
// the error status is clear. image_height is loaded through the config port;
// the user must load it while the block is idle; the block does not enforce it.
// If the master side stalls, the result register holds, the parser register
// fills, and then tready drops on the slave side until the result is taken.
// ----------------------------------------------------------------------------
module rgbe_rle_scanline_decoder #(
    parameter int MAX_LINE = rrle_pkg::MAX_LINE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,      // image_height
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tuser,   // [0] command
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata,   // red, green, blue, last_of_image, zero pad
    output logic [2:0]   o_m_axis_tuser,   // [2:0] status
    output logic         o_m_axis_tlast    // last_of_line
);
    logic [15:0]      r_height;
    rrle_pkg::t_s1    s1;
    rrle_pkg::t_entry rd [4];
    logic             adv, accept;
    logic [31:0]      red, green, blue;
    logic             loi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= 16'd0;
        end else if (i_cfg_we) begin
            r_height <= i_cfg_wdata;
        end
    end

    assign adv             = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = !s1.valid || adv;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    rrle_front #(.MAX_LINE(MAX_LINE)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_adv     (adv),
        .i_command (i_s_axis_tuser),
        .i_byte    (i_s_axis_tdata),
        .i_height  (r_height),
        .o_s1      (s1),
        .o_rd      (rd)
    );

    rrle_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_s1     (s1),
        .i_rd     (rd),
        .o_valid  (o_m_axis_tvalid),
        .o_status (o_m_axis_tuser),
        .o_red    (red),
        .o_green  (green),
        .o_blue   (blue),
        .o_lol    (o_m_axis_tlast),
        .o_loi    (loi)
    );

    assign o_m_axis_tdata = {7'd0, loi, blue, green, red};
endmodule
